// ===== rtl/dbtp_pkg.sv =====
// Shared types, codes and constants of the disc brush tile painter.
`timescale 1ns / 1ps

package dbtp_pkg;

    localparam int MAP_COLS_DEF   = 256;
    localparam int MAP_ROWS_DEF   = 128;
    localparam int MAX_RADIUS_DEF = 50;

    localparam int COLS_W = 9;
    localparam int ROWS_W = 8;
    localparam int CX_W   = 8;
    localparam int CY_W   = 7;
    localparam int RAD_W  = 6;
    localparam int MAT_W  = 3;
    localparam int CRD_W  = 12;
    localparam int DLT_W  = 7;
    localparam int SQ_W   = 12;

    localparam logic [COLS_W-1:0] COLS_RST = 9'd160;
    localparam logic [ROWS_W-1:0] ROWS_RST = 8'd90;

    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    localparam logic [MAT_W-1:0] MAT_EMPTY  = 3'd0;
    localparam logic [MAT_W-1:0] MAT_SOURCE = 3'd3;
    localparam logic [MAT_W-1:0] MAT_GOAL   = 3'd4;

    typedef enum logic [1:0] {
        KIND_PAINT = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_VALID        = 3'd0,
        ST_NO_SOURCE    = 3'd1,
        ST_MULTI_SOURCE = 3'd2,
        ST_NO_GOAL      = 3'd3,
        ST_MULTI_GOAL   = 3'd4
    } t_status;

    typedef struct packed {
        t_kind             kind;
        logic [CX_W-1:0]   cx;
        logic [CY_W-1:0]   cy;
        logic [RAD_W-1:0]  radius;
        logic [MAT_W-1:0]  material;
    } t_item;

    typedef struct packed {
        logic [MAT_W-1:0] cell_mat;
        t_status          status;
    } t_result;

endpackage

// ===== rtl/dbtp_tile_mem.sv =====
// Tile map memory: one write port, one registered read port, write-to-read forwarding.
`timescale 1ns / 1ps

module dbtp_tile_mem
    import dbtp_pkg::*;
#(
    parameter int DEPTH  = MAP_COLS_DEF * MAP_ROWS_DEF,
    parameter int ADDR_W = $clog2(MAP_COLS_DEF * MAP_ROWS_DEF)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [MAT_W-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [MAT_W-1:0]  o_rdata
);

    logic [MAT_W-1:0] r_mem [DEPTH];
    logic [MAT_W-1:0] r_rdata;
    logic [MAT_W-1:0] r_fwd_data;
    logic             r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata    <= r_mem[i_raddr];
        r_fwd_data <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else begin
            r_fwd <= i_we && (i_waddr == i_raddr);
        end
    end

    assign o_rdata = r_fwd ? r_fwd_data : r_rdata;

endmodule

// ===== rtl/dbtp_seq.sv =====
// Item sequencer: disc walk, unique-material scan, clearing sweep and map counts.
`timescale 1ns / 1ps

module dbtp_seq
    import dbtp_pkg::*;
#(
    parameter int MAP_COLS   = MAP_COLS_DEF,
    parameter int MAP_ROWS   = MAP_ROWS_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF,
    parameter int ADDR_W     = $clog2(MAP_COLS_DEF * MAP_ROWS_DEF)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [COLS_W-1:0] i_cols,
    input  logic [ROWS_W-1:0] i_rows,
    input  logic              i_item_vld,
    input  t_item             i_item,
    output logic              o_ready,
    input  logic              i_res_rdy,
    output logic              o_res_vld,
    output t_result           o_res,
    output logic              o_mem_we,
    output logic [ADDR_W-1:0] o_mem_waddr,
    output logic [MAT_W-1:0]  o_mem_wdata,
    output logic [ADDR_W-1:0] o_mem_raddr,
    input  logic [MAT_W-1:0]  i_mem_rdata
);

    localparam int CELLS = MAP_COLS * MAP_ROWS;
    localparam int CNT_W = $clog2(CELLS + 1);

    typedef enum logic [7:0] {
        S_WIPE = 8'b0000_0001,
        S_IDLE = 8'b0000_0010,
        S_DISC = 8'b0000_0100,
        S_SCAN = 8'b0000_1000,
        S_MARK = 8'b0001_0000,
        S_LOOK = 8'b0010_0000,
        S_WAIT = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_PUT  = 2'd1,
        OP_SCAN = 2'd2,
        OP_LOOK = 2'd3
    } t_op;

    t_state            r_state, n_state;
    logic              r_wipe_look, n_wipe_look;
    logic [ADDR_W-1:0] r_ptr, n_ptr;
    t_op               r_s1_op, n_s1_op;
    logic [ADDR_W-1:0] r_s1_addr, n_s1_addr;
    logic [MAT_W-1:0]  r_s1_mat, n_s1_mat;
    logic [CNT_W-1:0]  r_src, n_src;
    logic [CNT_W-1:0]  r_goal, n_goal;

    logic [CX_W-1:0]   r_cx, n_cx;
    logic [CY_W-1:0]   r_cy, n_cy;
    logic [RAD_W-1:0]  r_rad, n_rad;
    logic [SQ_W-1:0]   r_r2, n_r2;
    logic [MAT_W-1:0]  r_mat, n_mat;
    logic              r_uniq, n_uniq;
    logic [DLT_W-1:0]  r_dx, n_dx;
    logic [DLT_W-1:0]  r_dy, n_dy;
    logic [SQ_W-1:0]   r_dx2, n_dx2;
    logic [SQ_W-1:0]   r_dy2, n_dy2;
    logic              r_any, n_any;
    logic [ADDR_W-1:0] r_last, n_last;
    logic              r_mark_en, n_mark_en;
    logic [MAT_W-1:0]  r_cell, n_cell;

    logic [CRD_W-1:0]  eff_cols, eff_rows;
    logic [CRD_W-1:0]  px, py;
    logic              inb, in_disc, hit;
    logic [SQ_W:0]     sum_sq;
    logic [DLT_W-1:0]  rad7;
    logic              end_row, disc_end;
    logic [SQ_W-1:0]   dx2_step, dy2_step;
    logic [ADDR_W-1:0] disc_addr, home_addr, item_addr;
    logic              home_in, item_here;
    logic [RAD_W-1:0]  sat_rad;
    logic [MAT_W-1:0]  item_mat;
    logic              s1_we;
    logic [MAT_W-1:0]  s1_wdata;
    logic [MAT_W-1:0]  old;
    logic              wipe;

    assign eff_cols = ({3'b0, i_cols} > CRD_W'(MAP_COLS)) ? CRD_W'(MAP_COLS) : {3'b0, i_cols};
    assign eff_rows = ({4'b0, i_rows} > CRD_W'(MAP_ROWS)) ? CRD_W'(MAP_ROWS) : {4'b0, i_rows};

    assign px = {4'b0, r_cx} + {{5{r_dx[DLT_W-1]}}, r_dx};
    assign py = {5'b0, r_cy} + {{5{r_dy[DLT_W-1]}}, r_dy};
    assign inb = !px[CRD_W-1] && !py[CRD_W-1] && (px < eff_cols) && (py < eff_rows);
    assign sum_sq  = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign in_disc = sum_sq <= {1'b0, r_r2};
    assign hit     = in_disc && inb;
    assign rad7    = {1'b0, r_rad};
    assign end_row  = r_dx == rad7;
    assign disc_end = end_row && (r_dy == rad7);
    assign dx2_step = SQ_W'({1'b0, r_dx2} + {{5{r_dx[DLT_W-1]}}, r_dx, 1'b1});
    assign dy2_step = SQ_W'({1'b0, r_dy2} + {{5{r_dy[DLT_W-1]}}, r_dy, 1'b1});

    assign disc_addr = ADDR_W'(32'(py) * MAP_COLS + 32'(px));
    assign home_addr = ADDR_W'(32'(r_cy) * MAP_COLS + 32'(r_cx));
    assign item_addr = ADDR_W'(32'(i_item.cy) * MAP_COLS + 32'(i_item.cx));
    assign home_in   = ({4'b0, r_cx} < eff_cols) && ({5'b0, r_cy} < eff_rows);
    assign item_here = ({4'b0, i_item.cx} < eff_cols) && ({5'b0, i_item.cy} < eff_rows);

    assign sat_rad  = (i_item.radius == '0) ? RAD_W'(1) :
                      (i_item.radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : i_item.radius;
    assign item_mat = (i_item.material > MAT_GOAL) ? MAT_EMPTY : i_item.material;

    assign old  = i_mem_rdata;
    assign wipe = r_state == S_WIPE;

    always_comb begin
        s1_we    = 1'b0;
        s1_wdata = r_s1_mat;
        unique case (r_s1_op)
            OP_PUT: begin
                s1_we    = 1'b1;
                s1_wdata = r_s1_mat;
            end
            OP_SCAN: begin
                s1_we    = old == r_mat;
                s1_wdata = MAT_EMPTY;
            end
            OP_LOOK, OP_NONE: begin
                s1_we = 1'b0;
            end
        endcase
    end

    assign o_mem_we    = wipe || s1_we;
    assign o_mem_waddr = wipe ? r_ptr : r_s1_addr;
    assign o_mem_wdata = wipe ? MAT_EMPTY : s1_wdata;

    always_comb begin
        n_state     = r_state;
        n_wipe_look = r_wipe_look;
        n_ptr       = r_ptr;
        n_s1_op     = OP_NONE;
        n_s1_addr   = r_s1_addr;
        n_s1_mat    = r_s1_mat;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_rad       = r_rad;
        n_r2        = r_r2;
        n_mat       = r_mat;
        n_uniq      = r_uniq;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_dx2       = r_dx2;
        n_dy2       = r_dy2;
        n_any       = r_any;
        n_last      = r_last;
        n_mark_en   = r_mark_en;
        n_cell      = r_cell;
        o_mem_raddr = '0;

        n_src  = r_src;
        n_goal = r_goal;
        if (s1_we) begin
            n_src  = r_src - CNT_W'(old == MAT_SOURCE) + CNT_W'(s1_wdata == MAT_SOURCE);
            n_goal = r_goal - CNT_W'(old == MAT_GOAL) + CNT_W'(s1_wdata == MAT_GOAL);
        end

        unique case (r_state)
            S_WIPE: begin
                n_ptr = r_ptr + 1'b1;
                if (r_ptr == ADDR_W'(CELLS - 1)) begin
                    n_ptr       = '0;
                    n_wipe_look = 1'b0;
                    n_state     = r_wipe_look ? S_LOOK : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_item_vld) begin
                    n_cx      = i_item.cx;
                    n_cy      = i_item.cy;
                    n_rad     = sat_rad;
                    n_r2      = SQ_W'(sat_rad) * SQ_W'(sat_rad);
                    n_mat     = item_mat;
                    n_uniq    = (item_mat == MAT_SOURCE) || (item_mat == MAT_GOAL);
                    n_dx      = -{1'b0, sat_rad};
                    n_dy      = -{1'b0, sat_rad};
                    n_dx2     = SQ_W'(sat_rad) * SQ_W'(sat_rad);
                    n_dy2     = SQ_W'(sat_rad) * SQ_W'(sat_rad);
                    n_any     = 1'b0;
                    n_ptr     = '0;
                    n_mark_en = 1'b0;
                    unique case (i_item.kind)
                        KIND_PAINT: n_state = S_DISC;
                        KIND_WRITE: begin
                            n_mark_en = item_here;
                            n_last    = item_addr;
                            n_state   = S_MARK;
                        end
                        KIND_CLEAR: begin
                            n_src       = '0;
                            n_goal      = '0;
                            n_wipe_look = 1'b1;
                            n_state     = S_WIPE;
                        end
                        KIND_READ: n_state = S_LOOK;
                    endcase
                end
            end
            S_DISC: begin
                if (hit) begin
                    n_s1_op     = OP_PUT;
                    n_s1_addr   = disc_addr;
                    n_s1_mat    = r_uniq ? MAT_EMPTY : r_mat;
                    o_mem_raddr = disc_addr;
                    n_any       = 1'b1;
                    n_last      = disc_addr;
                end
                if (end_row) begin
                    n_dx  = -rad7;
                    n_dx2 = r_r2;
                    n_dy  = r_dy + 1'b1;
                    n_dy2 = dy2_step;
                end else begin
                    n_dx  = r_dx + 1'b1;
                    n_dx2 = dx2_step;
                end
                if (disc_end) begin
                    if (r_uniq && (r_any || hit)) begin
                        n_ptr     = '0;
                        n_mark_en = 1'b1;
                        n_state   = S_SCAN;
                    end else begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_SCAN: begin
                n_s1_op     = OP_SCAN;
                n_s1_addr   = r_ptr;
                o_mem_raddr = r_ptr;
                n_ptr       = r_ptr + 1'b1;
                if (r_ptr == ADDR_W'(CELLS - 1)) begin
                    n_ptr   = '0;
                    n_state = S_MARK;
                end
            end
            S_MARK: begin
                if (r_mark_en) begin
                    n_s1_op     = OP_PUT;
                    n_s1_addr   = r_last;
                    n_s1_mat    = r_mat;
                    o_mem_raddr = r_last;
                end
                n_state = S_LOOK;
            end
            S_LOOK: begin
                n_s1_op     = OP_LOOK;
                n_s1_addr   = home_in ? home_addr : '0;
                o_mem_raddr = home_in ? home_addr : '0;
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                n_cell  = home_in ? old : MAT_EMPTY;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_rdy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_WIPE;
            r_wipe_look <= 1'b0;
            r_ptr       <= '0;
            r_s1_op     <= OP_NONE;
            r_src       <= '0;
            r_goal      <= '0;
        end else begin
            r_state     <= n_state;
            r_wipe_look <= n_wipe_look;
            r_ptr       <= n_ptr;
            r_s1_op     <= n_s1_op;
            r_src       <= n_src;
            r_goal      <= n_goal;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= n_s1_addr;
        r_s1_mat  <= n_s1_mat;
        r_cx      <= n_cx;
        r_cy      <= n_cy;
        r_rad     <= n_rad;
        r_r2      <= n_r2;
        r_mat     <= n_mat;
        r_uniq    <= n_uniq;
        r_dx      <= n_dx;
        r_dy      <= n_dy;
        r_dx2     <= n_dx2;
        r_dy2     <= n_dy2;
        r_any     <= n_any;
        r_last    <= n_last;
        r_mark_en <= n_mark_en;
        r_cell    <= n_cell;
    end

    assign o_ready   = r_state == S_IDLE;
    assign o_res_vld = (r_state == S_DONE) && i_res_rdy;
    assign o_res.cell_mat = r_cell;

    always_comb begin
        priority if (r_src == '0) begin
            o_res.status = ST_NO_SOURCE;
        end else if (r_src > CNT_W'(1)) begin
            o_res.status = ST_MULTI_SOURCE;
        end else if (r_goal == '0) begin
            o_res.status = ST_NO_GOAL;
        end else if (r_goal > CNT_W'(1)) begin
            o_res.status = ST_MULTI_GOAL;
        end else begin
            o_res.status = ST_VALID;
        end
    end

endmodule

// ===== rtl/disc_brush_tile_painter_unit.sv =====
// Top level of the disc brush tile painter: stream ports, size registers, result register.
//
// Slave stream takes one item per transfer: tuser carries the kind (paint disc, write cell,
// clear map, read cell), tdata the cell or disc center, radius and material. The master
// stream returns one result per item: the material at the addressed cell after the item
// and the source/goal validation status. Size registers are written on the plain write port.
// Work from the accepting edge to m_axis_tvalid, with r the saturated radius and
// N = MAP_COLS * MAP_ROWS cells:
//   read cell: look up the cell; write cell: place the cell, then look it up
//   paint disc: walk the (2r+1)^2 square around the center; a source or goal disc that
//     touches the map then scans all N cells of the map and places the cell
//   clear map: clearing sweep over all N cells, then look up the cell
// The tile map sits in one memory with a single write port, one cell per cycle.
// s_axis_tready rises together with m_axis_tvalid when the result loads; items are taken one at a time.
// After reset the block runs a clearing pass over all N cells (32768 by default) with
// s_axis_tready low; configuration writes are taken meanwhile.
// The result waits in an output register; the next item is accepted while it waits, and
// its own result holds inside the block until the receiver has taken the previous one.
`timescale 1ns / 1ps

module disc_brush_tile_painter_unit
    import dbtp_pkg::*;
#(
    parameter int MAP_COLS   = MAP_COLS_DEF,
    parameter int MAP_ROWS   = MAP_ROWS_DEF,
    parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [COLS_W-1:0] i_cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [23:0]       s_axis_tdata,   // center_x, center_y, brush_radius, material
    input  logic [1:0]        s_axis_tuser,   // kind
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata    // cell_material, map_status, zero pad
);

    localparam int CELLS  = MAP_COLS * MAP_ROWS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

    logic [COLS_W-1:0] r_cols;
    logic [ROWS_W-1:0] r_rows;
    logic              r_m_vld;
    logic [7:0]        r_m_data;

    t_item             item;
    t_result           res;
    logic              seq_ready;
    logic              seq_res_vld;
    logic              slot_free;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [MAT_W-1:0]  mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [MAT_W-1:0]  mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RST;
            r_rows <= ROWS_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_COLS) begin
                r_cols <= i_cfg_data;
            end else if (i_cfg_index == CFG_ROWS) begin
                r_rows <= i_cfg_data[ROWS_W-1:0];
            end
        end
    end

    assign item.kind     = t_kind'(s_axis_tuser);
    assign item.cx       = s_axis_tdata[7:0];
    assign item.cy       = s_axis_tdata[14:8];
    assign item.radius   = s_axis_tdata[20:15];
    assign item.material = s_axis_tdata[23:21];

    assign slot_free = !r_m_vld || m_axis_tready;

    dbtp_seq #(
        .MAP_COLS   (MAP_COLS),
        .MAP_ROWS   (MAP_ROWS),
        .MAX_RADIUS (MAX_RADIUS),
        .ADDR_W     (ADDR_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cols      (r_cols),
        .i_rows      (r_rows),
        .i_item_vld  (s_axis_tvalid),
        .i_item      (item),
        .o_ready     (seq_ready),
        .i_res_rdy   (slot_free),
        .o_res_vld   (seq_res_vld),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    dbtp_tile_mem #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (seq_res_vld) begin
            r_m_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_res_vld) begin
            r_m_data <= {2'b00, res.status, res.cell_mat};
        end
    end

    assign s_axis_tready = seq_ready;
    assign m_axis_tvalid = r_m_vld;
    assign m_axis_tdata  = r_m_data;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("item accepted while the previous one is in progress");

    a_slot_free_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_res_vld |-> (!r_m_vld || m_axis_tready))
        else $error("result loaded over an untaken result");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[5:3] <= 3'd4))
        else $error("status code out of range");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench of the disc brush tile painter: directed and random map edits.
`timescale 1ns / 1ps

module testbench;
    import dbtp_pkg::*;

    localparam int GRID_COLS  = MAP_COLS_DEF;
    localparam int GRID_ROWS  = MAP_ROWS_DEF;
    localparam int GRID_CELLS = GRID_COLS * GRID_ROWS;
    localparam int RADIUS_CAP = MAX_RADIUS_DEF;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic              i_cfg_index   = CFG_COLS;
    logic [COLS_W-1:0] i_cfg_data    = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [23:0]       s_axis_tdata  = '0;  // center_x, center_y, brush_radius, material
    logic [1:0]        s_axis_tuser  = KIND_READ;  // kind
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;        // cell_material, map_status, zero pad

    logic [MAT_W-1:0] grid_model [GRID_CELLS];
    int               source_cells;
    int               goal_cells;
    int               cols_setting = COLS_RST;
    int               rows_setting = ROWS_RST;
    t_result          cell_results [$];
    int               error_count      = 0;
    int               send_idle_pct    = 0;
    int               recv_idle_pct    = 0;
    int               recv_hold_cycles = 0;
    int               scans_left       = 12;

    disc_brush_tile_painter_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic int eff_cols();
        return (cols_setting > GRID_COLS) ? GRID_COLS : cols_setting;
    endfunction

    function automatic int eff_rows();
        return (rows_setting > GRID_ROWS) ? GRID_ROWS : rows_setting;
    endfunction

    function automatic bit in_map(input int x, input int y);
        return x >= 0 && y >= 0 && x < eff_cols() && y < eff_rows();
    endfunction

    function automatic void set_cell(input int idx, input logic [MAT_W-1:0] mat);
        if (grid_model[idx] == MAT_SOURCE) source_cells--;
        if (grid_model[idx] == MAT_GOAL) goal_cells--;
        if (mat == MAT_SOURCE) source_cells++;
        if (mat == MAT_GOAL) goal_cells++;
        grid_model[idx] = mat;
    endfunction

    function automatic void clear_grid();
        foreach (grid_model[i]) grid_model[i] = MAT_EMPTY;
        source_cells = 0;
        goal_cells   = 0;
    endfunction

    function automatic t_status grid_status();
        if (source_cells == 0) return ST_NO_SOURCE;
        if (source_cells > 1) return ST_MULTI_SOURCE;
        if (goal_cells == 0) return ST_NO_GOAL;
        if (goal_cells > 1) return ST_MULTI_GOAL;
        return ST_VALID;
    endfunction

    // Source and goal keep only the last in-bounds disc cell in raster order.
    function automatic void paint_disc(input int cx, input int cy, input int r,
                                       input logic [MAT_W-1:0] mat);
        bit sole;
        bit hit;
        int last_idx;
        int dy;
        int dx;
        sole     = (mat == MAT_SOURCE) || (mat == MAT_GOAL);
        hit      = 1'b0;
        last_idx = 0;
        for (dy = -r; dy <= r; dy++) begin
            for (dx = -r; dx <= r; dx++) begin
                if (dx * dx + dy * dy <= r * r && in_map(cx + dx, cy + dy)) begin
                    if (sole && !hit) begin
                        foreach (grid_model[i]) begin
                            if (grid_model[i] == mat) set_cell(i, MAT_EMPTY);
                        end
                    end
                    hit      = 1'b1;
                    last_idx = (cy + dy) * GRID_COLS + cx + dx;
                    set_cell(last_idx, sole ? MAT_EMPTY : mat);
                end
            end
        end
        if (sole && hit) set_cell(last_idx, mat);
    endfunction

    function automatic void predict_item(input t_item it);
        int               cx;
        int               cy;
        int               r;
        logic [MAT_W-1:0] mat;
        bit               here;
        t_result          res;
        cx   = it.cx;
        cy   = it.cy;
        r    = it.radius;
        mat  = (it.material > MAT_GOAL) ? MAT_EMPTY : it.material;
        here = in_map(cx, cy);
        if (r < 1) r = 1;
        if (r > RADIUS_CAP) r = RADIUS_CAP;
        case (it.kind)
            KIND_PAINT: paint_disc(cx, cy, r, mat);
            KIND_WRITE: if (here) set_cell(cy * GRID_COLS + cx, mat);
            KIND_CLEAR: clear_grid();
            default: ;
        endcase
        res.cell_mat = here ? grid_model[cy * GRID_COLS + cx] : MAT_EMPTY;
        res.status   = grid_status();
        cell_results.push_back(res);
    endfunction

    task automatic send_item(input t_kind kind, input int cx, input int cy, input int radius,
                             input int mat);
        t_item it;
        it.kind     = kind;
        it.cx       = cx[CX_W-1:0];
        it.cy       = cy[CY_W-1:0];
        it.radius   = radius[RAD_W-1:0];
        it.material = mat[MAT_W-1:0];
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.material, it.radius, it.cy, it.cx};
        s_axis_tuser  <= it.kind;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_item(it);
    endtask

    task automatic wait_results_done();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (cell_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_map_size(input int cols, input int rows);
        wait_results_done();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_COLS;
        i_cfg_data  <= cols[COLS_W-1:0];
        @(negedge i_clk);
        i_cfg_index <= CFG_ROWS;
        i_cfg_data  <= {1'b0, rows[ROWS_W-1:0]};
        @(negedge i_clk);
        i_cfg_we     <= 1'b0;
        cols_setting = cols & 'h1FF;
        rows_setting = rows & 'hFF;
    endtask

    task automatic test_reset_state();
        send_item(KIND_READ, 0, 0, 0, 0);
        send_item(KIND_READ, 159, 89, 63, 7);
        send_item(KIND_READ, 160, 89, 0, 0);
    endtask

    task automatic test_single_writes();
        send_item(KIND_WRITE, 0, 0, 0, MAT_SOURCE);
        send_item(KIND_WRITE, 159, 89, 0, MAT_GOAL);
        send_item(KIND_WRITE, 10, 10, 5, MAT_SOURCE);
        send_item(KIND_WRITE, 10, 10, 0, 7);
        send_item(KIND_WRITE, 255, 5, 0, 2);
    endtask

    task automatic test_paint_discs();
        send_item(KIND_PAINT, 20, 20, 0, 1);
        send_item(KIND_PAINT, 80, 45, 63, 2);
        send_item(KIND_PAINT, 0, 0, 3, MAT_SOURCE);
        send_item(KIND_PAINT, 159, 89, 2, MAT_GOAL);
        send_item(KIND_PAINT, 200, 120, 5, MAT_GOAL);
        send_item(KIND_PAINT, 170, 100, 1, MAT_SOURCE);
    endtask

    task automatic test_size_registers();
        set_map_size(256, 128);
        send_item(KIND_WRITE, 255, 127, 0, 2);
        set_map_size(511, 255);
        send_item(KIND_READ, 255, 127, 0, 0);
        set_map_size(0, 1);
        send_item(KIND_PAINT, 0, 0, 1, MAT_SOURCE);
        set_map_size(1, 0);
        send_item(KIND_WRITE, 0, 0, 0, 1);
        set_map_size(1, 1);
        send_item(KIND_PAINT, 0, 0, 5, MAT_GOAL);
        set_map_size(COLS_RST, ROWS_RST);
    endtask

    task automatic test_clear_map();
        send_item(KIND_CLEAR, 255, 127, 63, 7);
        send_item(KIND_READ, 80, 45, 0, 0);
    endtask

    task automatic test_output_stall();
        int n;
        wait_results_done();
        send_idle_pct    = 0;
        recv_hold_cycles = 600;
        for (n = 0; n < 6; n++) begin
            send_item((n % 2) ? KIND_READ : KIND_WRITE, 30 + n, 40, 0, n);
        end
        wait_results_done();
    endtask

    task automatic test_random_items(input int count, input int send_pct, input int recv_pct);
        t_kind kind;
        int    cx;
        int    cy;
        int    rad;
        int    mat;
        int    pick;
        int    last_cx;
        int    last_cy;
        set_map_size($urandom_range(256, 1), $urandom_range(128, 1));
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        last_cx = 0;
        last_cy = 0;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 3 && scans_left > 0) begin
                kind = KIND_CLEAR;
                scans_left--;
            end else if (pick < 50) begin
                kind = KIND_PAINT;
            end else if (pick < 75) begin
                kind = KIND_WRITE;
            end else begin
                kind = KIND_READ;
            end
            cx  = ($urandom_range(4) == 0) ? $urandom_range(255) : $urandom_range(eff_cols() - 1);
            cy  = ($urandom_range(4) == 0) ? $urandom_range(127) : $urandom_range(eff_rows() - 1);
            rad = ($urandom_range(11) == 0) ? $urandom_range(63) : $urandom_range(6);
            mat = $urandom_range(7);
            if (kind == KIND_PAINT && (mat == MAT_SOURCE || mat == MAT_GOAL)) begin
                if (scans_left > 0 && $urandom_range(2) == 0) scans_left--;
                else mat = $urandom_range(2);
            end
            if (kind == KIND_READ && $urandom_range(1) == 0) begin
                cx = last_cx;
                cy = last_cy;
            end
            if (kind == KIND_PAINT || kind == KIND_WRITE) begin
                last_cx = cx;
                last_cy = cy;
            end
            send_item(kind, cx, cy, rad, mat);
        end
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (recv_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                recv_hold_cycles--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (cell_results.size() == 0) begin
                $display("%0t: transfer with no result pending: expected none, actual %h",
                         $time, m_axis_tdata);
                error_count++;
            end else begin
                want = cell_results.pop_front();
                if (m_axis_tdata[2:0] !== want.cell_mat) begin
                    $display("%0t: cell_material expected %0d actual %0d",
                             $time, want.cell_mat, m_axis_tdata[2:0]);
                    error_count++;
                end
                if (m_axis_tdata[5:3] !== want.status) begin
                    $display("%0t: map_status expected %0d actual %0d",
                             $time, want.status, m_axis_tdata[5:3]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #500_000_000;
        $display("[disc_brush_tile_painter_unit] ERROR");
        $finish;
    end

    initial begin
        clear_grid();
        send_idle_pct = 24;
        recv_idle_pct = 54;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_map_size(COLS_RST, ROWS_RST);
        test_reset_state();
        test_single_writes();
        test_paint_discs();
        test_size_registers();
        test_clear_map();
        test_output_stall();
        test_random_items(38, 24, 54);
        test_random_items(38, 54, 24);
        test_random_items(37, 0, 0);
        wait_results_done();
        repeat (64) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[disc_brush_tile_painter_unit] OK");
        end else begin
            $display("[disc_brush_tile_painter_unit] ERROR");
        end
        $finish;
    end

endmodule
